// ===== sv/grdda_pkg.sv =====
`timescale 1ns / 1ps
package grdda_pkg;

  // default sizing of the map and the distance path
  localparam int MAP_DIM_LOG2_DEF = 6;
  localparam int CELL_BITS_DEF    = 4;
  localparam int DIST_BITS_DEF    = 32;

  // fixed port widths
  localparam int COORD_W  = 6;
  localparam int VALUE_W  = 4;
  localparam int DIST_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FACE_W   = 2;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_HIT   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WRITE = 2'd2;

  // face codes
  localparam logic [FACE_W-1:0] FACE_NEG_X = 2'd0;
  localparam logic [FACE_W-1:0] FACE_POS_X = 2'd1;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 2'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 2'd3;

endpackage

// ===== sv/grdda_map.sv =====
`timescale 1ns / 1ps
module grdda_map #(
  parameter int AW        = 12,
  parameter int CELL_BITS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  output logic                 busy,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [CELL_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [CELL_BITS-1:0] rd_data
);
  import grdda_pkg::*;

  logic [CELL_BITS-1:0] map_mem [2**AW];
  logic [AW-1:0]        clr_addr;

  // clearing sweep after reset, one cell a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == '1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      map_mem[clr_addr] <= '0;
    end else if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= map_mem[rd_addr];
    end
  end

endmodule

// ===== sv/grid_ray_dda_walker.sv =====
`timescale 1ns / 1ps
// grid ray walker: a square cell map plus a dda stepper over it.
// command channel (cmd_valid / cmd_stall) takes one word per item: opcode 0
// stores cell_value at (cell_x, cell_y), opcode 1 casts a ray from that cell
// with the given side distances, deltas and step directions.
// result channel (res_valid / res_stall) returns one word per command: a write
// acknowledge, a wall hit with cell, value, side, face and end distances, or a
// miss when the ray would leave the map.
// order: a write goes straight to S_DONE after it is taken; a cast runs
// S_STEP and S_CHECK in turn for each cell it enters, waiting in S_CHECK for
// the map read, until a wall is hit in S_CHECK or a step would leave the map
// (at most about 2*MAP_DIM cells crossed), then loads its result in S_DONE.
// one command is in flight at a time; cmd_stall is high from the accepting
// edge until the result is loaded, so a new command waits for that load.
// the result sits in an output register, so the next command is taken while
// a result still waits; a stalled result holds and the finished item waits
// behind it.
// after reset the map is cleared by a sweep over all MAP_DIM*MAP_DIM cells
// (4096 by default) during which cmd_stall stays high.
module grid_ray_dda_walker #(
  parameter int MAP_DIM_LOG2 = grdda_pkg::MAP_DIM_LOG2_DEF,
  parameter int CELL_BITS    = grdda_pkg::CELL_BITS_DEF,
  parameter int DIST_BITS    = grdda_pkg::DIST_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  logic                            opcode,
  input  logic [grdda_pkg::COORD_W-1:0]   cell_x,
  input  logic [grdda_pkg::COORD_W-1:0]   cell_y,
  input  logic [grdda_pkg::VALUE_W-1:0]   cell_value,
  input  logic [grdda_pkg::DIST_W-1:0]    start_dist_x,
  input  logic [grdda_pkg::DIST_W-1:0]    start_dist_y,
  input  logic [grdda_pkg::DIST_W-1:0]    delta_x,
  input  logic [grdda_pkg::DIST_W-1:0]    delta_y,
  input  logic                            step_x_neg,
  input  logic                            step_y_neg,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [grdda_pkg::STATUS_W-1:0]  status,
  output logic [grdda_pkg::COORD_W-1:0]   hit_x,
  output logic [grdda_pkg::COORD_W-1:0]   hit_y,
  output logic [grdda_pkg::VALUE_W-1:0]   hit_value,
  output logic                            hit_side,
  output logic [grdda_pkg::FACE_W-1:0]    face,
  output logic [grdda_pkg::DIST_W-1:0]    end_dist_x,
  output logic [grdda_pkg::DIST_W-1:0]    end_dist_y
);
  import grdda_pkg::*;

  localparam int L  = MAP_DIM_LOG2;
  localparam int AW = 2 * MAP_DIM_LOG2;

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_CHECK, S_DONE} state_t;

  state_t               state;
  logic [L-1:0]         walk_x;
  logic [L-1:0]         walk_y;
  logic [DIST_BITS-1:0] acc_x;
  logic [DIST_BITS-1:0] acc_y;
  logic [DIST_BITS-1:0] dlt_x;
  logic [DIST_BITS-1:0] dlt_y;
  logic                 neg_x;
  logic                 neg_y;
  logic                 side;
  logic [STATUS_W-1:0]  res_status;
  logic [CELL_BITS-1:0] res_value;

  logic                 map_busy;
  logic                 cmd_fire;
  logic                 wr_en;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [CELL_BITS-1:0] rd_data;

  // port to internal width conversions
  logic [L+COORD_W-1:0]          in_x_ext;
  logic [L+COORD_W-1:0]          in_y_ext;
  logic [CELL_BITS+VALUE_W-1:0]  in_val_ext;
  logic [DIST_BITS+DIST_W-1:0]   in_sdx_ext;
  logic [DIST_BITS+DIST_W-1:0]   in_sdy_ext;
  logic [DIST_BITS+DIST_W-1:0]   in_dx_ext;
  logic [DIST_BITS+DIST_W-1:0]   in_dy_ext;
  logic [L+COORD_W-1:0]          out_x_ext;
  logic [L+COORD_W-1:0]          out_y_ext;
  logic [CELL_BITS+VALUE_W-1:0]  out_val_ext;
  logic [DIST_BITS+DIST_W-1:0]   out_dx_ext;
  logic [DIST_BITS+DIST_W-1:0]   out_dy_ext;

  assign in_x_ext    = {{L{1'b0}}, cell_x};
  assign in_y_ext    = {{L{1'b0}}, cell_y};
  assign in_val_ext  = {{CELL_BITS{1'b0}}, cell_value};
  assign in_sdx_ext  = {{DIST_BITS{1'b0}}, start_dist_x};
  assign in_sdy_ext  = {{DIST_BITS{1'b0}}, start_dist_y};
  assign in_dx_ext   = {{DIST_BITS{1'b0}}, delta_x};
  assign in_dy_ext   = {{DIST_BITS{1'b0}}, delta_y};
  assign out_x_ext   = {{COORD_W{1'b0}}, walk_x};
  assign out_y_ext   = {{COORD_W{1'b0}}, walk_y};
  assign out_val_ext = {{VALUE_W{1'b0}}, res_value};
  assign out_dx_ext  = {{DIST_W{1'b0}}, acc_x};
  assign out_dy_ext  = {{DIST_W{1'b0}}, acc_y};

  assign cmd_stall = (state != S_IDLE) || map_busy;
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign wr_en     = cmd_fire && (opcode == OP_WRITE);

  // one dda step
  logic                 step_y;
  logic [DIST_BITS:0]   sum_x;
  logic [DIST_BITS:0]   sum_y;
  logic [DIST_BITS-1:0] sat_x;
  logic [DIST_BITS-1:0] sat_y;
  logic                 x_edge;
  logic                 y_edge;
  logic                 oom;
  logic [L-1:0]         nx;
  logic [L-1:0]         ny;
  logic [L-1:0]         nwx;
  logic [L-1:0]         nwy;

  always_comb begin
    step_y = !(acc_x < acc_y); // ties step y
    sum_x  = {1'b0, acc_x} + {1'b0, dlt_x};
    sum_y  = {1'b0, acc_y} + {1'b0, dlt_y};
    sat_x  = sum_x[DIST_BITS] ? '1 : sum_x[DIST_BITS-1:0];
    sat_y  = sum_y[DIST_BITS] ? '1 : sum_y[DIST_BITS-1:0];
    x_edge = neg_x ? (walk_x == '0) : (walk_x == '1);
    y_edge = neg_y ? (walk_y == '0) : (walk_y == '1);
    nx     = neg_x ? walk_x - L'(1) : walk_x + L'(1);
    ny     = neg_y ? walk_y - L'(1) : walk_y + L'(1);
    oom    = step_y ? y_edge : x_edge;
    nwx    = (!step_y && !x_edge) ? nx : walk_x;
    nwy    = (step_y && !y_edge) ? ny : walk_y;
  end

  assign rd_en   = (state == S_STEP) && !oom;
  assign rd_addr = {nwx, nwy};

  grdda_map #(
    .AW        (AW),
    .CELL_BITS (CELL_BITS)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .busy    (map_busy),
    .wr_en   (wr_en),
    .wr_addr ({in_x_ext[L-1:0], in_y_ext[L-1:0]}),
    .wr_data (in_val_ext[CELL_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // in S_DONE the output register is reloaded below instead
      if (res_valid && !res_stall && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            if (opcode == OP_WRITE) begin
              res_status <= ST_WRITE;
              state      <= S_DONE;
            end else begin
              walk_x <= in_x_ext[L-1:0];
              walk_y <= in_y_ext[L-1:0];
              acc_x  <= in_sdx_ext[DIST_BITS-1:0];
              acc_y  <= in_sdy_ext[DIST_BITS-1:0];
              dlt_x  <= in_dx_ext[DIST_BITS-1:0];
              dlt_y  <= in_dy_ext[DIST_BITS-1:0];
              neg_x  <= step_x_neg;
              neg_y  <= step_y_neg;
              state  <= S_STEP;
            end
          end
        end
        S_STEP: begin
          side   <= step_y;
          walk_x <= nwx;
          walk_y <= nwy;
          if (step_y) begin
            acc_y <= sat_y;
          end else begin
            acc_x <= sat_x;
          end
          if (oom) begin
            res_status <= ST_MISS;
            res_value  <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // map word for the cell just entered
          if (rd_data != '0) begin
            res_status <= ST_HIT;
            res_value  <= rd_data;
            state      <= S_DONE;
          end else begin
            state <= S_STEP;
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            status    <= res_status;
            state     <= S_IDLE;
            if (res_status == ST_WRITE) begin
              hit_x      <= '0;
              hit_y      <= '0;
              hit_value  <= '0;
              hit_side   <= 1'b0;
              face       <= '0;
              end_dist_x <= '0;
              end_dist_y <= '0;
            end else begin
              hit_x      <= out_x_ext[COORD_W-1:0];
              hit_y      <= out_y_ext[COORD_W-1:0];
              hit_value  <= out_val_ext[VALUE_W-1:0];
              hit_side   <= side;
              end_dist_x <= out_dx_ext[DIST_W-1:0];
              end_dist_y <= out_dy_ext[DIST_W-1:0];
              if (side) begin
                face <= neg_y ? FACE_NEG_Y : FACE_POS_Y;
              end else begin
                face <= neg_x ? FACE_NEG_X : FACE_POS_X;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
